/* hw/rtl/lcdfb_pkg.sv */
// Shared types and constants for the LCD frame buffer block.
// Operation codes, configuration register indexes and the controller/datapath
// command and status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lcdfb_pkg;

   typedef logic [1:0] op_type;

   localparam op_type OP_WRITE = 2'd0;
   localparam op_type OP_CLEAR = 2'd1;
   localparam op_type OP_OPEN  = 2'd2;
   localparam op_type OP_CLOSE = 2'd3;

   typedef logic [1:0] csr_index_type;

   localparam csr_index_type CSR_XOR_MODE         = 2'd0;
   localparam csr_index_type CSR_FOREGROUND_BLACK = 2'd1;
   localparam csr_index_type CSR_BACKGROUND_BLACK = 2'd2;

   localparam int BYTE_W = 8;
   localparam int WORD_W = 16;
   localparam int DIRTY_W = 12;

   localparam logic [WORD_W-1:0] FILL_BLACK = 16'h0000;
   localparam logic [WORD_W-1:0] FILL_WHITE = 16'hffff;

   // Controller to datapath
   typedef struct packed {
      logic capture;        // transaction accepted: latch fields, read word
      logic sweep_run;      // write fill word at sweep pointer and advance
      logic sweep_zero;     // sweep fills with zero (power-on pass)
      logic merge_commit;   // commit masked byte write and its response
      logic finish_commit;  // commit clear/open/close and its response
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      op_type op;
      logic   sweep_last;
   } dp_status_type;

endpackage

`default_nettype wire

/* hw/rtl/lcd_framebuffer_masked_write.sv */
// Top level of the monochrome LCD frame buffer with masked byte writes.
// Depends on lcdfb_pkg, lcdfb_ctrl, lcdfb_datapath (and lcdfb_ram below it).
//
// Frame buffer of BUFFER_WORDS 16-bit words addressed by byte. Each request
// transaction yields exactly one response. For a masked byte write the accept
// cycle reads the word from the single pixel RAM; then, once the response
// slot is free, the byte is merged and written back while the response is
// loaded. Open and close load their response once the slot is free. A clear
// writes one RAM word per cycle, then loads its response. After reset the RAM
// is swept to zero, during which no request is accepted; configuration writes
// are taken at any time. A response held in the output register does not stop
// the next request from being accepted.
`timescale 1ns / 1ps
`default_nettype none

module lcd_framebuffer_masked_write #(
   parameter int BUFFER_WORDS = 4096,
   parameter int SCAN_BYTES   = 8192
) (
   input  wire logic                          clock,
   input  wire logic                          reset,

   input  wire logic                          csr_write_enable,
   input  wire lcdfb_pkg::csr_index_type      csr_index,
   input  wire logic                          csr_write_data,

   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire lcdfb_pkg::op_type             req_operation,
   input  wire logic [15:0]                   req_byte_address,
   input  wire logic [7:0]                    req_write_data,
   input  wire logic [7:0]                    req_write_mask,

   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_byte_changed,
   output logic                               rsp_refresh_pending,
   output logic [lcdfb_pkg::DIRTY_W-1:0]      rsp_dirty_low,
   output logic [lcdfb_pkg::DIRTY_W-1:0]      rsp_dirty_high,
   output logic                               rsp_display_open
);

   import lcdfb_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   lcdfb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lcdfb_datapath #(
      .BUFFER_WORDS(BUFFER_WORDS),
      .SCAN_BYTES  (SCAN_BYTES)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .req_operation       (req_operation),
      .req_byte_address    (req_byte_address),
      .req_write_data      (req_write_data),
      .req_write_mask      (req_write_mask),
      .rsp_byte_changed    (rsp_byte_changed),
      .rsp_refresh_pending (rsp_refresh_pending),
      .rsp_dirty_low       (rsp_dirty_low),
      .rsp_dirty_high      (rsp_dirty_high),
      .rsp_display_open    (rsp_display_open)
   );

   // a changed byte always leaves a refresh pending
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_changed |-> rsp_refresh_pending)
      else $error("byte changed without refresh pending");

   // refresh flag is never cleared outside reset
   assert property (@(posedge clock) disable iff (reset)
      rsp_refresh_pending |=> rsp_refresh_pending)
      else $error("refresh flag dropped");

   // one transaction in work at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous one in work");

   // accept only needs the command path, never a pending sweep
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !cmd.sweep_run)
      else $error("request accepted during RAM sweep");

endmodule

`default_nettype wire

/* hw/rtl/lcdfb_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lcdfb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/lcdfb_ctrl.sv */
// Controller state machine for the LCD frame buffer.
// Depends on lcdfb_pkg for the command/status structs and operation codes.
`timescale 1ns / 1ps
`default_nettype none

module lcdfb_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire lcdfb_pkg::dp_status_type status,
   output lcdfb_pkg::dp_cmd_type       cmd
);

   import lcdfb_pkg::*;

   localparam logic [2:0] ST_INIT   = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_MERGE  = 3'd2;
   localparam logic [2:0] ST_SWEEP  = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       slot_free;
   logic       load;

   // response slot can take a new result this cycle
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            cmd.sweep_run  = 1'b1;
            cmd.sweep_zero = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
            end
         end
         ST_MERGE: begin
            if (slot_free) begin
               cmd.merge_commit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SWEEP: begin
            cmd.sweep_run = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               cmd.finish_commit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // next state after capture follows the requested operation (not yet latched)
      if (cmd.capture) begin
         unique case (status.op)
            OP_WRITE: state_in = ST_MERGE;
            OP_CLEAR: state_in = ST_SWEEP;
            default:  state_in = ST_FINISH;
         endcase
      end
   end

   assign load = cmd.merge_commit || cmd.finish_commit;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* hw/rtl/lcdfb_datapath.sv */
// Datapath of the LCD frame buffer: pixel RAM, byte merge, dirty range,
// display flags and configuration registers. Depends on lcdfb_pkg, lcdfb_ram.
`timescale 1ns / 1ps
`default_nettype none

module lcdfb_datapath #(
   parameter int BUFFER_WORDS = 4096,
   parameter int SCAN_BYTES   = 8192
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire lcdfb_pkg::dp_cmd_type         cmd,
   output lcdfb_pkg::dp_status_type           status,
   input  wire logic                          csr_write_enable,
   input  wire lcdfb_pkg::csr_index_type      csr_index,
   input  wire logic                          csr_write_data,
   input  wire lcdfb_pkg::op_type             req_operation,
   input  wire logic [15:0]                   req_byte_address,
   input  wire logic [7:0]                    req_write_data,
   input  wire logic [7:0]                    req_write_mask,
   output logic                               rsp_byte_changed,
   output logic                               rsp_refresh_pending,
   output logic [lcdfb_pkg::DIRTY_W-1:0]      rsp_dirty_low,
   output logic [lcdfb_pkg::DIRTY_W-1:0]      rsp_dirty_high,
   output logic                               rsp_display_open
);

   import lcdfb_pkg::*;

   localparam int AW   = $clog2(BUFFER_WORDS);
   localparam int PADW = 16 - AW;
   localparam logic [AW-1:0] LAST_WORD = AW'(BUFFER_WORDS - 1);

   // configuration
   logic xor_mode_ff;
   logic fg_black_ff;
   logic bg_black_ff;

   // latched transaction
   op_type        op_ff;
   logic [AW-1:0] idx_ff;
   logic          high_ff;
   logic [7:0]    data_ff;
   logic [7:0]    mask_ff;
   logic          active_ff;

   // block state
   logic [AW-1:0] sweep_ff;
   logic [AW-1:0] sweep_in;
   logic [AW-1:0] range_low_ff;
   logic [AW-1:0] range_low_in;
   logic [AW-1:0] range_high_ff;
   logic [AW-1:0] range_high_in;
   logic          refresh_ff;
   logic          refresh_in;
   logic          open_ff;
   logic          open_in;
   logic          changed_ff;

   // RAM
   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [WORD_W-1:0] ram_wdata;
   logic [WORD_W-1:0] ram_rdata;

   logic [14:0]       req_word;
   logic              req_active;
   logic [7:0]        old_byte;
   logic [7:0]        color_byte;
   logic [7:0]        new_byte;
   logic              changed;
   logic [WORD_W-1:0] merged_word;
   logic [WORD_W-1:0] fill_word;
   logic [15:0]       low_ext;
   logic [15:0]       high_ext;

   lcdfb_ram #(
      .WIDTH(WORD_W),
      .DEPTH(BUFFER_WORDS)
   ) u_ram (
      .clock    (clock),
      .we       (ram_we),
      .waddr    (ram_waddr),
      .wdata    (ram_wdata),
      .re       (cmd.capture),
      .raddr    (req_byte_address[AW:1]),
      .rdata_ff (ram_rdata)
   );

   // write takes effect only inside the scan area and the buffer, with a mask
   assign req_word   = req_byte_address[15:1];
   assign req_active = (req_write_mask != 8'h00)
                    && ({1'b0, req_byte_address} < 17'(SCAN_BYTES))
                    && ({1'b0, req_word} < 16'(BUFFER_WORDS));

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req_operation;
         idx_ff    <= req_word[AW-1:0];
         high_ff   <= req_byte_address[0];
         data_ff   <= req_write_data;
         mask_ff   <= req_write_mask;
         active_ff <= req_active;
      end
   end

   assign status.op         = req_operation;
   assign status.sweep_last = (sweep_ff == LAST_WORD);

   // byte merge
   assign old_byte   = high_ff ? ram_rdata[15:8] : ram_rdata[7:0];
   assign color_byte = data_ff ^ {BYTE_W{fg_black_ff}};
   always_comb begin
      if (xor_mode_ff) begin
         new_byte = (data_ff & mask_ff) ^ old_byte;
      end else begin
         new_byte = (color_byte & mask_ff) | (old_byte & ~mask_ff);
      end
   end
   assign changed     = active_ff && (new_byte != old_byte);
   assign merged_word = high_ff ? {new_byte, ram_rdata[7:0]} : {ram_rdata[15:8], new_byte};

   assign fill_word = (cmd.sweep_zero || bg_black_ff) ? FILL_BLACK : FILL_WHITE;

   always_comb begin
      if (cmd.sweep_run) begin
         ram_we    = 1'b1;
         ram_waddr = sweep_ff;
         ram_wdata = fill_word;
      end else begin
         ram_we    = cmd.merge_commit && changed;
         ram_waddr = idx_ff;
         ram_wdata = merged_word;
      end
   end

   assign sweep_in = status.sweep_last ? '0 : sweep_ff + AW'(1);

   always_comb begin
      range_low_in  = range_low_ff;
      range_high_in = range_high_ff;
      refresh_in    = refresh_ff;
      open_in       = open_ff;
      if (cmd.merge_commit && changed) begin
         if (idx_ff <= range_low_ff) begin
            range_low_in = idx_ff;
         end
         if (idx_ff >= range_high_ff) begin
            range_high_in = idx_ff;
         end
         refresh_in = 1'b1;
      end
      if (cmd.finish_commit) begin
         case (op_ff)
            OP_CLEAR: begin
               range_low_in  = '0;
               range_high_in = LAST_WORD;
               refresh_in    = 1'b1;
            end
            OP_OPEN: begin
               if (!open_ff) begin
                  refresh_in = 1'b1;
               end
               open_in = 1'b1;
            end
            OP_CLOSE: begin
               if (open_ff) begin
                  refresh_in = 1'b1;
               end
               open_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         xor_mode_ff   <= 1'b0;
         fg_black_ff   <= 1'b0;
         bg_black_ff   <= 1'b0;
         sweep_ff      <= '0;
         range_low_ff  <= '0;
         range_high_ff <= LAST_WORD;
         refresh_ff    <= 1'b0;
         open_ff       <= 1'b1;
         changed_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_XOR_MODE:         xor_mode_ff <= csr_write_data;
               CSR_FOREGROUND_BLACK: fg_black_ff <= csr_write_data;
               CSR_BACKGROUND_BLACK: bg_black_ff <= csr_write_data;
               default: begin
               end
            endcase
         end
         if (cmd.sweep_run) begin
            sweep_ff <= sweep_in;
         end
         range_low_ff  <= range_low_in;
         range_high_ff <= range_high_in;
         refresh_ff    <= refresh_in;
         open_ff       <= open_in;
         if (cmd.merge_commit) begin
            changed_ff <= changed;
         end else if (cmd.finish_commit) begin
            changed_ff <= 1'b0;
         end
      end
   end

   // flags and range only move on a commit, which needs a free response slot,
   // so they stand as the response payload
   assign low_ext  = {{PADW{1'b0}}, range_low_ff};
   assign high_ext = {{PADW{1'b0}}, range_high_ff};

   assign rsp_byte_changed    = changed_ff;
   assign rsp_refresh_pending = refresh_ff;
   assign rsp_dirty_low       = low_ext[DIRTY_W-1:0];
   assign rsp_dirty_high      = high_ext[DIRTY_W-1:0];
   assign rsp_display_open    = open_ff;

endmodule

`default_nettype wire

/* bench/tb_lcd_framebuffer_masked_write.sv */
// Self-checking bench for lcd_framebuffer_masked_write: directed and random
// transactions scored against a shadow frame buffer kept in the bench.
// Depends on lcdfb_pkg and the frame buffer RTL, top level and below.
`timescale 1ns / 1ps

module tb_lcd_framebuffer_masked_write;
   import lcdfb_pkg::*;

   localparam int BUFFER_WORDS = 4096;
   localparam int SCAN_BYTES   = 8192;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 20;

   typedef struct packed {
      logic               byte_changed;
      logic               refresh_pending;
      logic [DIRTY_W-1:0] dirty_low;
      logic [DIRTY_W-1:0] dirty_high;
      logic               display_open;
   } frame_response_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_write_enable = 1'b0;
   csr_index_type        csr_index = CSR_XOR_MODE;
   logic                 csr_write_data = 1'b0;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   op_type               req_operation = OP_WRITE;
   logic [15:0]          req_byte_address = '0;
   logic [7:0]           req_write_data = '0;
   logic [7:0]           req_write_mask = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_byte_changed;
   logic                 rsp_refresh_pending;
   logic [DIRTY_W-1:0]   rsp_dirty_low;
   logic [DIRTY_W-1:0]   rsp_dirty_high;
   logic                 rsp_display_open;

   // shadow copy of the frame buffer and its flags
   logic [15:0]          shadow_words [0:BUFFER_WORDS-1];
   logic                 shadow_open = 1'b1;
   logic                 shadow_refresh = 1'b0;
   int unsigned          shadow_first = 0;
   int unsigned          shadow_last = BUFFER_WORDS - 1;
   logic                 cfg_xor = 1'b0;
   logic                 cfg_fg_black = 1'b0;
   logic                 cfg_bg_black = 1'b0;

   frame_response_type   expected_responses [$];
   int                   error_count = 0;
   int                   cycle_count = 0;
   int                   accepted_count = 0;
   int                   checked_count = 0;
   int                   change_count = 0;
   int                   clear_count = 0;

   bit                   req_idle_on = 1'b1;
   logic                 rsp_idle_on = 1'b1;
   logic                 long_hold_req = 1'b0;
   bit                   hold_used = 1'b0;
   int                   hold_left = 0;
   int                   stall_left = 0;

   lcd_framebuffer_masked_write #(
      .BUFFER_WORDS (BUFFER_WORDS),
      .SCAN_BYTES   (SCAN_BYTES)
   ) uut (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_operation       (req_operation),
      .req_byte_address    (req_byte_address),
      .req_write_data      (req_write_data),
      .req_write_mask      (req_write_mask),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_byte_changed    (rsp_byte_changed),
      .rsp_refresh_pending (rsp_refresh_pending),
      .rsp_dirty_low       (rsp_dirty_low),
      .rsp_dirty_high      (rsp_dirty_high),
      .rsp_display_open    (rsp_display_open)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      for (int i = 0; i < BUFFER_WORDS; i++) shadow_words[i] = 16'h0000;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic frame_response_type frame_predict(op_type op, logic [15:0] addr,
                                                        logic [7:0] data, logic [7:0] mask);
      frame_response_type res;
      logic [15:0]        word;
      logic [7:0]         old_byte;
      logic [7:0]         new_byte;
      int unsigned        idx;
      res.byte_changed = 1'b0;
      case (op)
         OP_WRITE: begin
            idx = addr >> 1;
            if (mask != 8'h00 && addr < SCAN_BYTES && idx < BUFFER_WORDS) begin
               word = shadow_words[idx];
               old_byte = addr[0] ? word[15:8] : word[7:0];
               if (cfg_xor) begin
                  new_byte = (data & mask) ^ old_byte;
               end else begin
                  new_byte = cfg_fg_black ? ~data : data;
                  new_byte = (new_byte & mask) | (old_byte & ~mask);
               end
               if (new_byte != old_byte) begin
                  if (addr[0]) word[15:8] = new_byte;
                  else word[7:0] = new_byte;
                  shadow_words[idx] = word;
                  if (idx <= shadow_first) shadow_first = idx;
                  if (idx >= shadow_last) shadow_last = idx;
                  shadow_refresh = 1'b1;
                  res.byte_changed = 1'b1;
               end
            end
         end
         OP_CLEAR: begin
            for (int i = 0; i < BUFFER_WORDS; i++)
               shadow_words[i] = cfg_bg_black ? FILL_BLACK : FILL_WHITE;
            shadow_refresh = 1'b1;
            shadow_first = 0;
            shadow_last = BUFFER_WORDS - 1;
         end
         OP_OPEN: begin
            if (!shadow_open) shadow_refresh = 1'b1;
            shadow_open = 1'b1;
         end
         default: begin
            if (shadow_open) shadow_refresh = 1'b1;
            shadow_open = 1'b0;
         end
      endcase
      res.refresh_pending = shadow_refresh;
      res.dirty_low = shadow_first[DIRTY_W-1:0];
      res.dirty_high = shadow_last[DIRTY_W-1:0];
      res.display_open = shadow_open;
      return res;
   endfunction

   // Valid is lowered at the start of the next call, so a caller must follow
   // an accepted transaction at once with another send or with wait_idle.
   task automatic send_item(input op_type op, input logic [15:0] addr,
                            input logic [7:0] data, input logic [7:0] mask);
      int gap;
      gap = req_idle_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_byte_address <= addr;
      req_write_data <= data;
      req_write_mask <= mask;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_responses.push_back(frame_predict(op, addr, data, mask));
      accepted_count++;
      if (op == OP_CLEAR) clear_count++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_responses.size() != 0) @(posedge clock);
   endtask

   task automatic set_config(input logic xor_on, input logic fg_black, input logic bg_black);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_index <= CSR_XOR_MODE;
      csr_write_data <= xor_on;
      @(posedge clock);
      csr_index <= CSR_FOREGROUND_BLACK;
      csr_write_data <= fg_black;
      @(posedge clock);
      csr_index <= CSR_BACKGROUND_BLACK;
      csr_write_data <= bg_black;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_xor = xor_on;
      cfg_fg_black = fg_black;
      cfg_bg_black = bg_black;
      @(posedge clock);
   endtask

   // Mostly writes, many into a small hot area so bytes get rewritten.
   task automatic send_random_item(input int hot_base);
      int          r;
      int          a;
      int          m;
      logic [15:0] addr;
      logic [7:0]  mask;
      r = $urandom_range(0, 199);
      if (r < 3) begin
         send_item(OP_CLEAR, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
      end else if (r < 40) begin
         send_item(r[0] ? OP_OPEN : OP_CLOSE, 16'($urandom_range(0, 65535)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end else begin
         a = $urandom_range(0, 99);
         if (a < 45) addr = 16'(hot_base + $urandom_range(0, 31));
         else if (a < 85) addr = 16'($urandom_range(0, SCAN_BYTES - 1));
         else if (a < 95) addr = 16'($urandom_range(SCAN_BYTES, 65535));
         else case ($urandom_range(0, 3))
            0: addr = 16'h0000;
            1: addr = 16'(SCAN_BYTES - 1);
            2: addr = 16'(SCAN_BYTES);
            default: addr = 16'hffff;
         endcase
         m = $urandom_range(0, 99);
         if (m < 8) mask = 8'h00;
         else if (m < 30) mask = 8'hff;
         else mask = 8'($urandom_range(0, 255));
         send_item(OP_WRITE, addr, 8'($urandom_range(0, 255)), mask);
      end
   endtask

   task automatic test_ignored_writes();
      // fresh buffer: none of these may raise the refresh flag
      send_item(OP_WRITE, 16'h0000, 8'hff, 8'h00);
      send_item(OP_WRITE, 16'(SCAN_BYTES), 8'hff, 8'hff);
      send_item(OP_WRITE, 16'hffff, 8'hff, 8'hff);
      send_item(OP_WRITE, 16'h0000, 8'h00, 8'hff);
      send_item(OP_OPEN, 16'h0000, 8'h00, 8'h00);
   endtask

   task automatic test_colour_merge();
      send_item(OP_WRITE, 16'(SCAN_BYTES - 1), 8'hff, 8'hff);
      send_item(OP_WRITE, 16'h0000, 8'ha5, 8'hf0);
      send_item(OP_WRITE, 16'h0001, 8'h5a, 8'h0f);
      set_config(1'b0, 1'b1, 1'b0);
      send_item(OP_WRITE, 16'h0002, 8'h00, 8'hff);
      send_item(OP_WRITE, 16'h0002, 8'hc3, 8'h3c);
   endtask

   task automatic test_open_close();
      send_item(OP_CLOSE, 16'h0000, 8'h00, 8'h00);
      send_item(OP_CLOSE, 16'hffff, 8'hff, 8'hff);
      send_item(OP_OPEN, 16'h0000, 8'h00, 8'h00);
      send_item(OP_OPEN, 16'hffff, 8'hff, 8'hff);
   endtask

   task automatic test_xor_mode();
      set_config(1'b1, 1'b0, 1'b0);
      send_item(OP_WRITE, 16'h0002, 8'hff, 8'h81);
      send_item(OP_WRITE, 16'h0003, 8'hff, 8'hff);
      send_item(OP_WRITE, 16'h0003, 8'h00, 8'hff);
      send_item(OP_WRITE, 16'(SCAN_BYTES - 1), 8'h80, 8'h80);
   endtask

   task automatic test_clear_fill();
      set_config(1'b0, 1'b0, 1'b0);
      send_item(OP_CLEAR, 16'h0000, 8'h00, 8'h00);
      send_item(OP_WRITE, 16'h000a, 8'hff, 8'hff);
      set_config(1'b0, 1'b0, 1'b1);
      send_item(OP_CLEAR, 16'hffff, 8'hff, 8'hff);
      send_item(OP_WRITE, 16'h000a, 8'hff, 8'h01);
   endtask

   task automatic test_random_traffic(input int count);
      int hot_base;
      hot_base = $urandom_range(0, SCAN_BYTES - 32);
      for (int i = 0; i < count; i++) send_random_item(hot_base);
   endtask

   // Sink holds off while the source keeps offering back to back.
   task automatic test_backpressure();
      int hot_base;
      hot_base = $urandom_range(0, SCAN_BYTES - 32);
      req_idle_on = 1'b0;
      long_hold_req <= 1'b1;
      for (int i = 0; i < 40; i++) send_random_item(hot_base);
   endtask

   always @(posedge clock) begin
      if (long_hold_req && !hold_used) begin
         hold_used = 1'b1;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!rsp_idle_on) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 70) begin
         rsp_ready <= 1'b1;
      end else begin
         stall_left = pick_gap();
         rsp_ready <= 1'b0;
      end
   end

   task automatic compare_field(input string field_name, input int want, input int got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, field_name, want, got);
      end
   endtask

   always @(posedge clock) begin : response_check
      frame_response_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_responses.size() == 0) begin
            error_count++;
            $display("%0t: response with none expected, got changed=%0h refresh=%0h",
                     $time, rsp_byte_changed, rsp_refresh_pending);
         end else begin
            want = expected_responses.pop_front();
            checked_count++;
            if (want.byte_changed) change_count++;
            compare_field("byte_changed", want.byte_changed, rsp_byte_changed);
            compare_field("refresh_pending", want.refresh_pending, rsp_refresh_pending);
            compare_field("dirty_low", want.dirty_low, rsp_dirty_low);
            compare_field("dirty_high", want.dirty_high, rsp_dirty_high);
            compare_field("display_open", want.display_open, rsp_display_open);
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_ignored_writes();
      test_colour_merge();
      test_open_close();
      test_xor_mode();
      test_clear_fill();
      for (int c = 0; c < 8; c++) begin
         set_config(c[0], c[1], c[2]);
         req_idle_on = (c != 2 && c != 5);
         rsp_idle_on <= (c != 3 && c != 5);
         test_random_traffic(112);
         if (c == 3) test_backpressure();
      end
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Run covered %0d transactions, %0d responses scored, %0d bytes altered,",
               accepted_count, checked_count, change_count);
      $display("%0d clears, all eight register settings and one long sink hold-off.",
               clear_count);
      if (error_count == 0 && expected_responses.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d errors, %0d responses outstanding", error_count,
                  expected_responses.size());
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/lcdfb_pkg.sv
hw/rtl/lcdfb_ram.sv
hw/rtl/lcdfb_ctrl.sv
hw/rtl/lcdfb_datapath.sv
hw/rtl/lcd_framebuffer_masked_write.sv
bench/tb_lcd_framebuffer_masked_write.sv
